// ===== hdl/phdc_pkg.sv =====
// Shared types, widths and constants for the pH dosing controller.
package phdc_pkg;

   localparam int MV_W      = 12;
   localparam int LEVEL_W   = 12;
   localparam int PH_W      = 12;
   localparam int TARGET_W  = 11;
   localparam int OFFSET_W  = 10;
   localparam int TICKS_W   = 16;
   localparam int STARTED_W = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_PH_LOW_TARGET   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PH_HIGH_TARGET  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PH_OFFSET       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TANK_LOW_LIMIT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TANK_HIGH_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PUMP_ON_TICKS   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLDOFF_TICKS   = 3'd6;

   // Reset values of the configuration registers.
   localparam logic [TARGET_W-1:0] RST_PH_LOW_TARGET   = 11'd0;
   localparam logic [TARGET_W-1:0] RST_PH_HIGH_TARGET  = 11'd1400;
   localparam logic [OFFSET_W-1:0] RST_PH_OFFSET       = 10'd0;
   localparam logic [LEVEL_W-1:0]  RST_TANK_LOW_LIMIT  = 12'd0;
   localparam logic [LEVEL_W-1:0]  RST_TANK_HIGH_LIMIT = 12'd4095;
   localparam logic [TICKS_W-1:0]  RST_PUMP_ON_TICKS   = 16'd5;
   localparam logic [TICKS_W-1:0]  RST_HOLDOFF_TICKS   = 16'd60;

   // Input operation codes.
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_MEASURE = 1'b1;

   // Dose start codes.
   localparam logic [STARTED_W-1:0] DOSE_NONE = 2'd0;
   localparam logic [STARTED_W-1:0] DOSE_UP   = 2'd1;
   localparam logic [STARTED_W-1:0] DOSE_DOWN = 2'd2;

   localparam logic [TICKS_W-1:0] TICKS_ZERO = 16'd0;
   localparam logic [TICKS_W-1:0] TICKS_ONE  = 16'd1;

   // pH*100 = (785000 - 300*mV) / 455, rounded half away from zero.
   localparam int SCALED_W = 21;
   localparam int NUM_W    = 22;
   localparam int MAG_W    = 20;
   localparam int QMAG_W   = 12;
   localparam int SUM_W    = 13;
   localparam int PROD_W   = 42;
   localparam logic [SCALED_W-1:0] PH_SCALE    = 21'd300;
   localparam logic [NUM_W-1:0]    PH_NUM_BIAS = 22'd785000;
   localparam logic [MAG_W-1:0]    PH_ROUND    = 20'd227;
   // ceil(2^30 / 455); exact for every dividend below 2^20.
   localparam logic [PROD_W-1:0]   PH_RECIP       = 42'd2359873;
   localparam int                  PH_RECIP_SHIFT = 30;
   localparam logic signed [SUM_W-1:0] PH_MAX = 13'sd2047;
   localparam logic signed [SUM_W-1:0] PH_MIN = -13'sd2048;

   typedef struct packed {
      logic [TARGET_W-1:0] ph_low_target;
      logic [TARGET_W-1:0] ph_high_target;
      logic [LEVEL_W-1:0]  tank_low_limit;
      logic [LEVEL_W-1:0]  tank_high_limit;
      logic [TICKS_W-1:0]  pump_on_ticks;
      logic [TICKS_W-1:0]  holdoff_ticks;
   } dose_cfg_type;

   typedef struct packed {
      logic                    operation;
      logic [LEVEL_W-1:0]      tank_level;
      logic                    cycle_active;
      logic signed [PH_W-1:0]  ph_centi;
   } meas_type;

endpackage

// ===== hdl/phdc_convert.sv =====
// Two-stage conversion of the probe voltage to pH in hundredths.
module phdc_convert (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic                                 in_operation,
   input  logic [phdc_pkg::MV_W-1:0]            in_millivolts,
   input  logic [phdc_pkg::LEVEL_W-1:0]         in_tank_level,
   input  logic                                 in_cycle_active,
   input  logic [phdc_pkg::OFFSET_W-1:0]        ph_offset,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output phdc_pkg::meas_type                   out_meas
);

   // Stage one: magnitude of the numerator with the rounding bias.
   logic                                 s1_valid_ff, s1_valid_in;
   logic                                 s1_op_ff;
   logic [phdc_pkg::LEVEL_W-1:0]         s1_level_ff;
   logic                                 s1_active_ff;
   logic                                 s1_neg_ff, s1_neg_in;
   logic [phdc_pkg::MAG_W-1:0]           s1_mag_ff, s1_mag_in;
   logic                                 s1_ready;

   logic [phdc_pkg::SCALED_W-1:0]        mv_scaled;
   logic [phdc_pkg::NUM_W-1:0]           num;
   logic [phdc_pkg::NUM_W-1:0]           num_abs;

   // Stage two: signed, offset and clamped pH.
   logic                                 s2_valid_ff, s2_valid_in;
   phdc_pkg::meas_type                   s2_meas_ff, s2_meas_in;
   logic                                 s2_ready;

   logic [phdc_pkg::PROD_W-1:0]          prod;
   logic [phdc_pkg::QMAG_W-1:0]          q_mag;
   logic signed [phdc_pkg::SUM_W-1:0]    q_signed;
   logic signed [phdc_pkg::SUM_W-1:0]    q_sum;
   logic signed [phdc_pkg::SUM_W-1:0]    offset_ext;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      mv_scaled = phdc_pkg::SCALED_W'(in_millivolts) * phdc_pkg::PH_SCALE;
      num       = phdc_pkg::PH_NUM_BIAS - phdc_pkg::NUM_W'(mv_scaled);
      s1_neg_in = num[phdc_pkg::NUM_W-1];
      num_abs   = s1_neg_in ? (~num + phdc_pkg::NUM_W'(1)) : num;
      s1_mag_in = phdc_pkg::MAG_W'(num_abs) + phdc_pkg::PH_ROUND;
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_op_ff     <= in_operation;
         s1_level_ff  <= in_tank_level;
         s1_active_ff <= in_cycle_active;
         s1_neg_ff    <= s1_neg_in;
         s1_mag_ff    <= s1_mag_in;
      end
   end

   always_comb begin
      prod       = phdc_pkg::PROD_W'(s1_mag_ff) * phdc_pkg::PH_RECIP;
      q_mag      = prod[phdc_pkg::PH_RECIP_SHIFT +: phdc_pkg::QMAG_W];
      q_signed   = s1_neg_ff ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
      offset_ext = phdc_pkg::SUM_W'($signed(ph_offset));
      q_sum      = q_signed + offset_ext;

      s2_meas_in.operation    = s1_op_ff;
      s2_meas_in.tank_level   = s1_level_ff;
      s2_meas_in.cycle_active = s1_active_ff;
      if (q_sum > phdc_pkg::PH_MAX) begin
         s2_meas_in.ph_centi = phdc_pkg::PH_W'(phdc_pkg::PH_MAX);
      end else if (q_sum < phdc_pkg::PH_MIN) begin
         s2_meas_in.ph_centi = phdc_pkg::PH_W'(phdc_pkg::PH_MIN);
      end else begin
         s2_meas_in.ph_centi = q_sum[phdc_pkg::PH_W-1:0];
      end
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_meas_ff <= s2_meas_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_meas  = s2_meas_ff;

endmodule

// ===== hdl/phdc_dose.sv =====
// Dosing decision, pump and holdoff counters, and the result register.
module phdc_dose (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  phdc_pkg::meas_type                   in_meas,
   input  phdc_pkg::dose_cfg_type               cfg,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [phdc_pkg::PH_W-1:0]     rsp_ph_centi,
   output logic                                 rsp_pump_up_on,
   output logic                                 rsp_pump_down_on,
   output logic                                 rsp_dose_ready,
   output logic [phdc_pkg::STARTED_W-1:0]       rsp_dose_started,
   output logic                                 rsp_tank_wait
);

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 up_ff, up_in;
   logic                                 down_ff, down_in;
   logic                                 ready_ff, ready_in;
   logic [phdc_pkg::TICKS_W-1:0]         on_ff, on_in;
   logic [phdc_pkg::TICKS_W-1:0]         hold_ff, hold_in;
   logic signed [phdc_pkg::PH_W-1:0]     ph_ff, ph_in;
   logic [phdc_pkg::STARTED_W-1:0]       started_ff, started_in;
   logic                                 wait_ff, wait_in;
   logic                                 load;
   logic                                 in_band;
   logic signed [phdc_pkg::PH_W-1:0]     low_target;
   logic signed [phdc_pkg::PH_W-1:0]     high_target;

   // The state registers double as the result payload: they only change
   // when the previous result has been taken.
   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign load     = in_valid && in_ready;

   assign low_target  = $signed({1'b0, cfg.ph_low_target});
   assign high_target = $signed({1'b0, cfg.ph_high_target});
   assign in_band     = (in_meas.tank_level >= cfg.tank_low_limit) &&
                        (in_meas.tank_level <= cfg.tank_high_limit);

   always_comb begin
      up_in      = up_ff;
      down_in    = down_ff;
      ready_in   = ready_ff;
      on_in      = on_ff;
      hold_in    = hold_ff;
      ph_in      = ph_ff;
      started_in = phdc_pkg::DOSE_NONE;
      wait_in    = 1'b0;
      if (in_meas.operation == phdc_pkg::OP_TICK) begin
         if (on_ff != phdc_pkg::TICKS_ZERO) begin
            on_in = on_ff - phdc_pkg::TICKS_ONE;
            if (on_ff == phdc_pkg::TICKS_ONE) begin
               up_in   = 1'b0;
               down_in = 1'b0;
            end
         end
         if (hold_ff != phdc_pkg::TICKS_ZERO) begin
            hold_in = hold_ff - phdc_pkg::TICKS_ONE;
            if (hold_ff == phdc_pkg::TICKS_ONE) begin
               ready_in = 1'b1;
            end
         end
      end else begin
         ph_in = in_meas.ph_centi;
         if (in_meas.cycle_active) begin
            if (in_band) begin
               // A low reading that cannot dose does not fall through to the
               // high-side check.
               if (in_meas.ph_centi < low_target) begin
                  if (ready_ff) begin
                     up_in      = 1'b1;
                     started_in = phdc_pkg::DOSE_UP;
                  end
               end else if (in_meas.ph_centi > high_target) begin
                  if (ready_ff) begin
                     down_in    = 1'b1;
                     started_in = phdc_pkg::DOSE_DOWN;
                  end
               end
               if (started_in != phdc_pkg::DOSE_NONE) begin
                  on_in    = (cfg.pump_on_ticks == phdc_pkg::TICKS_ZERO) ?
                             phdc_pkg::TICKS_ONE : cfg.pump_on_ticks;
                  hold_in  = (cfg.holdoff_ticks == phdc_pkg::TICKS_ZERO) ?
                             phdc_pkg::TICKS_ONE : cfg.holdoff_ticks;
                  ready_in = 1'b0;
               end
            end else begin
               wait_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         up_ff        <= 1'b0;
         down_ff      <= 1'b0;
         ready_ff     <= 1'b1;
         on_ff        <= phdc_pkg::TICKS_ZERO;
         hold_ff      <= phdc_pkg::TICKS_ZERO;
         ph_ff        <= '0;
         started_ff   <= phdc_pkg::DOSE_NONE;
         wait_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            up_ff      <= up_in;
            down_ff    <= down_in;
            ready_ff   <= ready_in;
            on_ff      <= on_in;
            hold_ff    <= hold_in;
            ph_ff      <= ph_in;
            started_ff <= started_in;
            wait_ff    <= wait_in;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ph_centi     = ph_ff;
   assign rsp_pump_up_on   = up_ff;
   assign rsp_pump_down_on = down_ff;
   assign rsp_dose_ready   = ready_ff;
   assign rsp_dose_started = started_ff;
   assign rsp_tank_wait    = wait_ff;

   a_dose_arms_counters: assert property (@(posedge clock) disable iff (reset)
      load && (started_in != phdc_pkg::DOSE_NONE) |=>
         !ready_ff && (on_ff != phdc_pkg::TICKS_ZERO) && (hold_ff != phdc_pkg::TICKS_ZERO))
      else $error("dose did not arm the on-time and holdoff counters");

   a_pump_has_on_time: assert property (@(posedge clock) disable iff (reset)
      (up_ff || down_ff) |-> (on_ff != phdc_pkg::TICKS_ZERO))
      else $error("pump drive is on with no on-time remaining");

   a_not_ready_has_holdoff: assert property (@(posedge clock) disable iff (reset)
      !ready_ff |-> (hold_ff != phdc_pkg::TICKS_ZERO))
      else $error("ready is low with no holdoff remaining");

   a_wait_excludes_dose: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(wait_ff && (started_ff != phdc_pkg::DOSE_NONE)))
      else $error("a dose started on a transaction that reported tank wait");

endmodule

// ===== hdl/ph_dosing_controller.sv =====
// pH dosing controller top level: configuration registers and pipeline.
//
// Every request transaction, tick or measurement, gives exactly one response
// transaction. The block takes one request per clock cycle while responses are
// taken; a stalled response side fills the pipeline and then holds off requests.
// A response passes through three register stages: the voltage-to-numerator
// stage, the reciprocal multiplier that divides by 455 and applies offset and
// clamping, and the dosing decision stage that also holds the response.
// Configuration writes are taken in any cycle (csr_ready is always high) but
// are meant to be made only while no transaction is in flight. A write to an
// unused index is ignored.
module ph_dosing_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [phdc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [phdc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic [phdc_pkg::MV_W-1:0]            req_probe_millivolts,
   input  logic [phdc_pkg::LEVEL_W-1:0]         req_tank_level,
   input  logic                                 req_cycle_active,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [phdc_pkg::PH_W-1:0]     rsp_ph_centi,
   output logic                                 rsp_pump_up_on,
   output logic                                 rsp_pump_down_on,
   output logic                                 rsp_dose_ready,
   output logic [phdc_pkg::STARTED_W-1:0]       rsp_dose_started,
   output logic                                 rsp_tank_wait
);

   phdc_pkg::dose_cfg_type               cfg_ff, cfg_in;
   logic [phdc_pkg::OFFSET_W-1:0]        offset_ff, offset_in;
   logic                                 csr_write;

   logic                                 meas_valid;
   logic                                 meas_ready;
   phdc_pkg::meas_type                   meas;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in    = cfg_ff;
      offset_in = offset_ff;
      if (csr_write) begin
         case (csr_index)
            phdc_pkg::CSR_PH_LOW_TARGET: begin
               cfg_in.ph_low_target = csr_wdata[phdc_pkg::TARGET_W-1:0];
            end
            phdc_pkg::CSR_PH_HIGH_TARGET: begin
               cfg_in.ph_high_target = csr_wdata[phdc_pkg::TARGET_W-1:0];
            end
            phdc_pkg::CSR_PH_OFFSET: begin
               offset_in = csr_wdata[phdc_pkg::OFFSET_W-1:0];
            end
            phdc_pkg::CSR_TANK_LOW_LIMIT: begin
               cfg_in.tank_low_limit = csr_wdata[phdc_pkg::LEVEL_W-1:0];
            end
            phdc_pkg::CSR_TANK_HIGH_LIMIT: begin
               cfg_in.tank_high_limit = csr_wdata[phdc_pkg::LEVEL_W-1:0];
            end
            phdc_pkg::CSR_PUMP_ON_TICKS: begin
               cfg_in.pump_on_ticks = csr_wdata[phdc_pkg::TICKS_W-1:0];
            end
            phdc_pkg::CSR_HOLDOFF_TICKS: begin
               cfg_in.holdoff_ticks = csr_wdata[phdc_pkg::TICKS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ph_low_target   <= phdc_pkg::RST_PH_LOW_TARGET;
         cfg_ff.ph_high_target  <= phdc_pkg::RST_PH_HIGH_TARGET;
         cfg_ff.tank_low_limit  <= phdc_pkg::RST_TANK_LOW_LIMIT;
         cfg_ff.tank_high_limit <= phdc_pkg::RST_TANK_HIGH_LIMIT;
         cfg_ff.pump_on_ticks   <= phdc_pkg::RST_PUMP_ON_TICKS;
         cfg_ff.holdoff_ticks   <= phdc_pkg::RST_HOLDOFF_TICKS;
         offset_ff              <= phdc_pkg::RST_PH_OFFSET;
      end else begin
         cfg_ff    <= cfg_in;
         offset_ff <= offset_in;
      end
   end

   phdc_convert u_convert (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .in_operation    (req_operation),
      .in_millivolts   (req_probe_millivolts),
      .in_tank_level   (req_tank_level),
      .in_cycle_active (req_cycle_active),
      .ph_offset       (offset_ff),
      .out_valid       (meas_valid),
      .out_ready       (meas_ready),
      .out_meas        (meas)
   );

   phdc_dose u_dose (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (meas_valid),
      .in_ready         (meas_ready),
      .in_meas          (meas),
      .cfg              (cfg_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ph_centi     (rsp_ph_centi),
      .rsp_pump_up_on   (rsp_pump_up_on),
      .rsp_pump_down_on (rsp_pump_down_on),
      .rsp_dose_ready   (rsp_dose_ready),
      .rsp_dose_started (rsp_dose_started),
      .rsp_tank_wait    (rsp_tank_wait)
   );

endmodule

// ===== sim/ph_dosing_controller_tb.sv =====
// Self-checking testbench for the pH dosing controller, with directed and random tests.
`timescale 1ns / 100ps

module ph_dosing_controller_tb;

   // Index that maps to no register; writes to it must be dropped.
   localparam logic [phdc_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   localparam int PH_BIAS_NUM  = 785000;
   localparam int MV_SCALE_NUM = 300;
   localparam int MV_DIVISOR   = 455;
   localparam int PH_CLAMP_MAX = 2047;
   localparam int PH_CLAMP_MIN = -2048;
   localparam int OFFSET_MASK  = (1 << phdc_pkg::OFFSET_W) - 1;

   localparam int LONG_STALL_CYCLES = 80;
   localparam int DRAIN_CYCLES      = 12;
   localparam int RANDOM_PHASES     = 13;
   localparam int PHASE_ITEMS       = 48;

   typedef struct packed {
      logic signed [phdc_pkg::PH_W-1:0] ph_centi;
      logic                             pump_up_on;
      logic                             pump_down_on;
      logic                             dose_ready;
      logic [phdc_pkg::STARTED_W-1:0]   dose_started;
      logic                             tank_wait;
   } dose_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [phdc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [phdc_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic req_valid;
   logic req_ready;
   logic req_operation;
   logic [phdc_pkg::MV_W-1:0]    req_probe_millivolts;
   logic [phdc_pkg::LEVEL_W-1:0] req_tank_level;
   logic req_cycle_active;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [phdc_pkg::PH_W-1:0] rsp_ph_centi;
   logic rsp_pump_up_on;
   logic rsp_pump_down_on;
   logic rsp_dose_ready;
   logic [phdc_pkg::STARTED_W-1:0] rsp_dose_started;
   logic rsp_tank_wait;

   ph_dosing_controller dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_probe_millivolts (req_probe_millivolts),
      .req_tank_level       (req_tank_level),
      .req_cycle_active     (req_cycle_active),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ph_centi         (rsp_ph_centi),
      .rsp_pump_up_on       (rsp_pump_up_on),
      .rsp_pump_down_on     (rsp_pump_down_on),
      .rsp_dose_ready       (rsp_dose_ready),
      .rsp_dose_started     (rsp_dose_started),
      .rsp_tank_wait        (rsp_tank_wait)
   );

   always #2 clock = ~clock;

   // Predicted copy of the configuration registers.
   logic [phdc_pkg::TARGET_W-1:0]        cfg_low_target;
   logic [phdc_pkg::TARGET_W-1:0]        cfg_high_target;
   logic signed [phdc_pkg::OFFSET_W-1:0] cfg_offset;
   logic [phdc_pkg::LEVEL_W-1:0]         cfg_tank_low;
   logic [phdc_pkg::LEVEL_W-1:0]         cfg_tank_high;
   logic [phdc_pkg::TICKS_W-1:0]         cfg_on_ticks;
   logic [phdc_pkg::TICKS_W-1:0]         cfg_holdoff_ticks;

   // Predicted copy of the dosing state.
   logic                             up_drive;
   logic                             down_drive;
   logic                             ready_flag;
   logic [phdc_pkg::TICKS_W-1:0]     on_left;
   logic [phdc_pkg::TICKS_W-1:0]     holdoff_left;
   logic signed [phdc_pkg::PH_W-1:0] ph_latest;

   dose_result_type expected_results[$];
   dose_result_type want;
   int error_count = 0;

   int  burst_left = 0;
   bit  sender_gaps_on = 1'b1;
   bit  long_stall_req = 1'b0;

   function automatic void reset_predictor();
      cfg_low_target    = phdc_pkg::RST_PH_LOW_TARGET;
      cfg_high_target   = phdc_pkg::RST_PH_HIGH_TARGET;
      cfg_offset        = phdc_pkg::RST_PH_OFFSET;
      cfg_tank_low      = phdc_pkg::RST_TANK_LOW_LIMIT;
      cfg_tank_high     = phdc_pkg::RST_TANK_HIGH_LIMIT;
      cfg_on_ticks      = phdc_pkg::RST_PUMP_ON_TICKS;
      cfg_holdoff_ticks = phdc_pkg::RST_HOLDOFF_TICKS;
      up_drive     = 1'b0;
      down_drive   = 1'b0;
      ready_flag   = 1'b1;
      on_left      = phdc_pkg::TICKS_ZERO;
      holdoff_left = phdc_pkg::TICKS_ZERO;
      ph_latest    = '0;
   endfunction

   function automatic void apply_csr(input logic [phdc_pkg::CSR_INDEX_W-1:0] index,
                                     input logic [phdc_pkg::CSR_DATA_W-1:0] data);
      case (index)
         phdc_pkg::CSR_PH_LOW_TARGET:   cfg_low_target  = data[phdc_pkg::TARGET_W-1:0];
         phdc_pkg::CSR_PH_HIGH_TARGET:  cfg_high_target = data[phdc_pkg::TARGET_W-1:0];
         phdc_pkg::CSR_PH_OFFSET:       cfg_offset      = data[phdc_pkg::OFFSET_W-1:0];
         phdc_pkg::CSR_TANK_LOW_LIMIT:  cfg_tank_low    = data[phdc_pkg::LEVEL_W-1:0];
         phdc_pkg::CSR_TANK_HIGH_LIMIT: cfg_tank_high   = data[phdc_pkg::LEVEL_W-1:0];
         phdc_pkg::CSR_PUMP_ON_TICKS:   cfg_on_ticks    = data[phdc_pkg::TICKS_W-1:0];
         phdc_pkg::CSR_HOLDOFF_TICKS:   cfg_holdoff_ticks = data[phdc_pkg::TICKS_W-1:0];
         default: ;
      endcase
   endfunction

   // Advances the predicted state by one transaction and returns its response.
   function automatic dose_result_type predict_dose(input logic op,
                                                    input logic [phdc_pkg::MV_W-1:0] mv,
                                                    input logic [phdc_pkg::LEVEL_W-1:0] level,
                                                    input logic active);
      dose_result_type res;
      int num;
      int ph;
      logic [phdc_pkg::STARTED_W-1:0] started;
      logic wait_flag;
      started   = phdc_pkg::DOSE_NONE;
      wait_flag = 1'b0;
      if (op == phdc_pkg::OP_TICK) begin
         if (on_left != phdc_pkg::TICKS_ZERO) begin
            on_left = on_left - phdc_pkg::TICKS_ONE;
            if (on_left == phdc_pkg::TICKS_ZERO) begin
               up_drive   = 1'b0;
               down_drive = 1'b0;
            end
         end
         if (holdoff_left != phdc_pkg::TICKS_ZERO) begin
            holdoff_left = holdoff_left - phdc_pkg::TICKS_ONE;
            if (holdoff_left == phdc_pkg::TICKS_ZERO)
               ready_flag = 1'b1;
         end
      end else begin
         num = PH_BIAS_NUM - MV_SCALE_NUM * int'(mv);
         // Round half away from zero on both signs.
         if (num >= 0)
            ph = (num + MV_DIVISOR / 2) / MV_DIVISOR;
         else
            ph = -((-num + MV_DIVISOR / 2) / MV_DIVISOR);
         ph = ph + int'(cfg_offset);
         if (ph < PH_CLAMP_MIN) ph = PH_CLAMP_MIN;
         if (ph > PH_CLAMP_MAX) ph = PH_CLAMP_MAX;
         ph_latest = phdc_pkg::PH_W'(ph);
         if (active) begin
            if (level >= cfg_tank_low && level <= cfg_tank_high) begin
               if (ph < int'(cfg_low_target)) begin
                  if (ready_flag) begin
                     up_drive = 1'b1;
                     started  = phdc_pkg::DOSE_UP;
                  end
               end else if (ph > int'(cfg_high_target)) begin
                  if (ready_flag) begin
                     down_drive = 1'b1;
                     started    = phdc_pkg::DOSE_DOWN;
                  end
               end
               if (started != phdc_pkg::DOSE_NONE) begin
                  on_left      = (cfg_on_ticks == phdc_pkg::TICKS_ZERO) ?
                                 phdc_pkg::TICKS_ONE : cfg_on_ticks;
                  holdoff_left = (cfg_holdoff_ticks == phdc_pkg::TICKS_ZERO) ?
                                 phdc_pkg::TICKS_ONE : cfg_holdoff_ticks;
                  ready_flag   = 1'b0;
               end
            end else begin
               wait_flag = 1'b1;
            end
         end
      end
      res.ph_centi     = ph_latest;
      res.pump_up_on   = up_drive;
      res.pump_down_on = down_drive;
      res.dose_ready   = ready_flag;
      res.dose_started = started;
      res.tank_wait    = wait_flag;
      return res;
   endfunction

   // Watches all three channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            apply_csr(csr_index, csr_wdata);
         if (req_valid && req_ready)
            expected_results.push_back(predict_dose(req_operation, req_probe_millivolts,
                                                    req_tank_level, req_cycle_active));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ph_centi !== want.ph_centi) begin
                  $error("ph_centi: expected %0d, actual %0d", want.ph_centi, rsp_ph_centi);
                  error_count++;
               end
               if (rsp_pump_up_on !== want.pump_up_on) begin
                  $error("pump_up_on: expected %0d, actual %0d",
                         want.pump_up_on, rsp_pump_up_on);
                  error_count++;
               end
               if (rsp_pump_down_on !== want.pump_down_on) begin
                  $error("pump_down_on: expected %0d, actual %0d",
                         want.pump_down_on, rsp_pump_down_on);
                  error_count++;
               end
               if (rsp_dose_ready !== want.dose_ready) begin
                  $error("dose_ready: expected %0d, actual %0d",
                         want.dose_ready, rsp_dose_ready);
                  error_count++;
               end
               if (rsp_dose_started !== want.dose_started) begin
                  $error("dose_started: expected %0d, actual %0d",
                         want.dose_started, rsp_dose_started);
                  error_count++;
               end
               if (rsp_tank_wait !== want.tank_wait) begin
                  $error("tank_wait: expected %0d, actual %0d",
                         want.tank_wait, rsp_tank_wait);
                  error_count++;
               end
            end
         end
      end
   end

   // Response side: stretches of random stall patterns, plus one long hold-off on request.
   initial begin : rsp_side
      int mode;
      int stretch;
      int k;
      rsp_ready = 1'b0;
      forever begin
         if (long_stall_req) begin
            for (k = 0; k < LONG_STALL_CYCLES; k++) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
            long_stall_req = 1'b0;
         end else begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(8, 48);
            for (k = 0; k < stretch && !long_stall_req; k++) begin
               @(negedge clock);
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= ($urandom_range(0, 9) < 6);
                  default: rsp_ready <= k[1];
               endcase
            end
         end
      end
   end

   // Offers one request transaction and returns at the edge that accepts it.
   task automatic send_item(input logic op, input logic [phdc_pkg::MV_W-1:0] mv,
                            input logic [phdc_pkg::LEVEL_W-1:0] level, input logic active);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = (sender_gaps_on && $urandom_range(0, 1)) ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid            <= 1'b1;
      req_operation        <= op;
      req_probe_millivolts <= mv;
      req_tank_level       <= level;
      req_cycle_active     <= active;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [phdc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [phdc_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_dosing(input int low, input int high, input int offset,
                             input int tank_low, input int tank_high,
                             input int on_ticks, input int holdoff);
      write_reg(phdc_pkg::CSR_PH_LOW_TARGET, phdc_pkg::CSR_DATA_W'(low));
      write_reg(phdc_pkg::CSR_PH_HIGH_TARGET, phdc_pkg::CSR_DATA_W'(high));
      write_reg(phdc_pkg::CSR_PH_OFFSET, phdc_pkg::CSR_DATA_W'(offset & OFFSET_MASK));
      write_reg(phdc_pkg::CSR_TANK_LOW_LIMIT, phdc_pkg::CSR_DATA_W'(tank_low));
      write_reg(phdc_pkg::CSR_TANK_HIGH_LIMIT, phdc_pkg::CSR_DATA_W'(tank_high));
      write_reg(phdc_pkg::CSR_PUMP_ON_TICKS, phdc_pkg::CSR_DATA_W'(on_ticks));
      write_reg(phdc_pkg::CSR_HOLDOFF_TICKS, phdc_pkg::CSR_DATA_W'(holdoff));
      csr_release();
   endtask

   // Conversion at the voltage extremes and offset clamping, with dosing disabled.
   task automatic test_conversion();
      send_item(phdc_pkg::OP_TICK, 12'd0, 12'd0, 1'b0);
      send_item(phdc_pkg::OP_MEASURE, 12'd0, 12'd2000, 1'b0);
      send_item(phdc_pkg::OP_MEASURE, 12'd4095, 12'd4095, 1'b0);
      send_item(phdc_pkg::OP_MEASURE, 12'd1555, 12'd0, 1'b0);
      wait_drained();
      set_dosing(0, 1400, 500, 0, 4095, 5, 60);
      send_item(phdc_pkg::OP_MEASURE, 12'd0, 12'd100, 1'b0);
      wait_drained();
      set_dosing(0, 1400, -512, 0, 4095, 5, 60);
      send_item(phdc_pkg::OP_MEASURE, 12'd4095, 12'd100, 1'b0);
      wait_drained();
   endtask

   // Up and down doses, the ready holdoff, pump expiry and the tank band edges.
   task automatic test_dosing();
      set_dosing(700, 800, 0, 1000, 2000, 2, 3);
      send_item(phdc_pkg::OP_MEASURE, 12'd1800, 12'd1500, 1'b1);
      send_item(phdc_pkg::OP_MEASURE, 12'd1300, 12'd1000, 1'b1);
      send_item(phdc_pkg::OP_TICK, 12'd0, 12'd0, 1'b0);
      send_item(phdc_pkg::OP_TICK, 12'd0, 12'd0, 1'b0);
      send_item(phdc_pkg::OP_TICK, 12'd0, 12'd0, 1'b0);
      send_item(phdc_pkg::OP_MEASURE, 12'd1300, 12'd2000, 1'b1);
      send_item(phdc_pkg::OP_MEASURE, 12'd1800, 12'd999, 1'b1);
      send_item(phdc_pkg::OP_MEASURE, 12'd1800, 12'd2001, 1'b1);
      send_item(phdc_pkg::OP_MEASURE, 12'd1800, 12'd0, 1'b0);
      wait_drained();
   endtask

   // Inverted tank limits report a wait; zero tick counts behave as one tick.
   task automatic test_band_and_zero_ticks();
      set_dosing(700, 800, 0, 3000, 100, 0, 0);
      send_item(phdc_pkg::OP_MEASURE, 12'd1800, 12'd2000, 1'b1);
      wait_drained();
      set_dosing(700, 800, 0, 0, 4095, 0, 0);
      send_item(phdc_pkg::OP_MEASURE, 12'd1800, 12'd2000, 1'b1);
      send_item(phdc_pkg::OP_TICK, 12'd0, 12'd0, 1'b0);
      wait_drained();
   endtask

   // A second dose while the first pump still runs, with the longest on time.
   task automatic test_overlap();
      set_dosing(700, 800, 0, 0, 4095, 65535, 1);
      send_item(phdc_pkg::OP_MEASURE, 12'd1800, 12'd2000, 1'b1);
      send_item(phdc_pkg::OP_TICK, 12'd0, 12'd0, 1'b0);
      send_item(phdc_pkg::OP_MEASURE, 12'd1300, 12'd2000, 1'b1);
      wait_drained();
      set_dosing(700, 800, 0, 0, 4095, 1, 1);
      send_item(phdc_pkg::OP_TICK, 12'd0, 12'd0, 1'b0);
      send_item(phdc_pkg::OP_MEASURE, 12'd1800, 12'd2000, 1'b1);
      send_item(phdc_pkg::OP_TICK, 12'd0, 12'd0, 1'b0);
      wait_drained();
   endtask

   // Registers at extreme values (high target and tank high limit at zero), then a write to the unused index.
   task automatic test_register_extremes();
      set_dosing(2047, 0, 511, 4095, 0, 65535, 65535);
      send_item(phdc_pkg::OP_MEASURE, 12'd0, 12'd4095, 1'b0);
      wait_drained();
      write_reg(CSR_UNUSED, 16'hFFFF);
      csr_release();
      send_item(phdc_pkg::OP_MEASURE, 12'd2010, 12'd0, 1'b0);
      wait_drained();
   endtask

   // The response side holds off while requests keep coming, so the pipeline fills.
   task automatic test_backpressure();
      int n;
      set_dosing(600, 900, 0, 0, 4095, 3, 5);
      sender_gaps_on = 1'b0;
      long_stall_req = 1'b1;
      for (n = 0; n < 30; n++)
         send_item(($urandom_range(0, 1) == 0) ? phdc_pkg::OP_TICK : phdc_pkg::OP_MEASURE,
                   phdc_pkg::MV_W'($urandom_range(1000, 2300)),
                   phdc_pkg::LEVEL_W'($urandom_range(0, 4095)), 1'b1);
      sender_gaps_on = 1'b1;
      wait_drained();
   endtask

   // Random settings per phase; most measurements land near the targets and in band.
   task automatic test_random_phases();
      int phase;
      int n;
      int low;
      int high;
      int offset;
      int tank_low;
      int tank_high;
      logic op;
      logic [phdc_pkg::MV_W-1:0] mv;
      logic [phdc_pkg::LEVEL_W-1:0] level;
      logic active;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if ($urandom_range(0, 6) == 0) begin
            low  = $urandom_range(0, 2047);
            high = $urandom_range(0, 2047);
         end else begin
            low  = $urandom_range(450, 750);
            high = low + $urandom_range(0, 300);
         end
         offset    = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 100) - 50
                                                : $urandom_range(0, 1023) - 512;
         tank_low  = $urandom_range(0, 1500);
         tank_high = $urandom_range(2500, 4095);
         if ($urandom_range(0, 9) == 0) begin
            tank_low  = $urandom_range(2000, 4095);
            tank_high = $urandom_range(0, 1999);
         end
         set_dosing(low, high, offset, tank_low, tank_high,
                    $urandom_range(0, 8), $urandom_range(0, 12));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            op     = ($urandom_range(0, 99) < 45) ? phdc_pkg::OP_TICK : phdc_pkg::OP_MEASURE;
            mv     = ($urandom_range(0, 4) == 0) ? phdc_pkg::MV_W'($urandom_range(0, 4095))
                                                 : phdc_pkg::MV_W'($urandom_range(1000, 2300));
            level  = ($urandom_range(0, 4) == 0 || tank_low > tank_high)
                     ? phdc_pkg::LEVEL_W'($urandom_range(0, 4095))
                     : phdc_pkg::LEVEL_W'($urandom_range(tank_low, tank_high));
            active = ($urandom_range(0, 9) != 0);
            send_item(op, mv, level, active);
         end
         wait_drained();
      end
   endtask

   initial begin
      reset                = 1'b1;
      csr_valid            = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_valid            = 1'b0;
      req_operation        = phdc_pkg::OP_TICK;
      req_probe_millivolts = '0;
      req_tank_level       = '0;
      req_cycle_active     = 1'b0;
      reset_predictor();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_conversion();
      test_dosing();
      test_band_and_zero_ticks();
      test_overlap();
      test_register_extremes();
      test_backpressure();
      test_random_phases();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/phdc_pkg.sv
hdl/phdc_convert.sv
hdl/phdc_dose.sv
hdl/ph_dosing_controller.sv
sim/ph_dosing_controller_tb.sv
